@@ design/sop_pkg.sv @@
// shared types, constants and codes for the sampled offset prefetcher
package sop_pkg;

   localparam int ADDR_W          = 48;
   localparam int BLOCK_SHIFT     = 6;
   localparam int PRED_DEPTH      = 1024;
   localparam int CONF_BITS       = 3;
   localparam int SAMPLER_DEPTH   = 256;
   localparam int SAMPLER_WAYS    = 4;
   localparam int INIT_CONFIDENCE = 4;

   localparam int SAMPLER_SETS = SAMPLER_DEPTH / SAMPLER_WAYS;
   localparam int SET_BITS     = $clog2(SAMPLER_SETS);
   localparam int TAG_W        = ADDR_W - BLOCK_SHIFT - SET_BITS;
   localparam int SIG_W        = $clog2(PRED_DEPTH);
   localparam int WAY_W        = (SAMPLER_WAYS > 1) ? $clog2(SAMPLER_WAYS) : 1;
   localparam int CONF_MAX     = (1 << CONF_BITS) - 1;
   localparam int INIT_CONF    = (INIT_CONFIDENCE > CONF_MAX) ? CONF_MAX : INIT_CONFIDENCE;

   localparam int THR_W         = 7;
   localparam int DEG_W         = 4;
   localparam int MAX_DEGREE    = 8;
   localparam int PERCENT_SCALE = 100;
   localparam int CMP_W         = 16;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 8;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE    = CSR_IDX_W'(1);
   localparam logic [THR_W-1:0] THRESHOLD_RESET = THR_W'(50);
   localparam logic [DEG_W-1:0] DEGREE_RESET    = DEG_W'(2);

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic              has_pc;
      logic [ADDR_W-1:0] pc;
      logic [ADDR_W-1:0] address;
      logic              secure;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0] prefetch_address;
      logic              last;
   } rsp_type;

   typedef struct packed {
      logic [ADDR_W-1:0] pc;
      logic [ADDR_W-1:0] address;
      logic              secure;
   } job_type;

   typedef struct packed {
      logic              secure;
      logic [TAG_W-1:0]  tag;
      logic [SIG_W-1:0]  sig;
      logic [ADDR_W-1:0] last_address;
      logic [WAY_W-1:0]  age;
   } way_type;

   typedef way_type [SAMPLER_WAYS-1:0] row_type;

   typedef struct packed {
      logic [CONF_BITS-1:0] conf;
      logic [ADDR_W-1:0]    offset;
   } pred_type;

   typedef struct packed {
      logic pop;
      logic clearing;
   } back_status_type;

   typedef enum logic [2:0] {
      S_CLEAR,
      S_IDLE,
      S_LOOKUP,
      S_TRAIN,
      S_CHECK,
      S_EMIT
   } state_type;

endpackage

@@ design/sampled_offset_prefetcher_unit.sv @@
// top level of the sampled offset prefetcher: control registers and front/back hookup
//
// usage:
//   req_valid/req_ready/req_data carry one cache access word (has_pc, pc, address,
//   secure). words with has_pc low are taken and dropped. accepted words go into a
//   two-entry queue, so the requester keeps going while the engine is busy.
//   rsp_valid/rsp_ready/rsp_data carry prefetch address words; the final word of
//   an access has last set. an access that is not confident gives no words.
//   csr_valid/csr_ready/csr_index/csr_data write threshold (index 0, low 7 bits)
//   and degree (index 1, low 4 bits); csr_ready is always high.
//   timing: each access passes through the engine in order (queue pop, sampler row
//   read, predictor read-modify-write, confidence test), paced by the single
//   port of each memory, then one prefetch word per cycle while rsp_ready is high.
//   the engine finishes one access before it pops the next from the queue.
//   the first word follows the lookup, train and check states.
//   after reset all 1024 predictor entries are swept to their initial value,
//   with req_ready low; the sampler resets at once through per-entry valid bits.
//   a stalled rsp_ready holds the current word and halts the engine; the queue
//   still takes words until it is full.
module sampled_offset_prefetcher_unit
   import sop_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_type               req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_type               rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   logic [THR_W-1:0] threshold_ff;
   logic [DEG_W-1:0] degree_ff;
   back_status_type  status;
   logic             q_valid;
   job_type          q_item;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         threshold_ff <= THRESHOLD_RESET;
         degree_ff    <= DEGREE_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_THRESHOLD: threshold_ff <= csr_data[THR_W-1:0];
            CSR_DEGREE:    degree_ff    <= csr_data[DEG_W-1:0];
            default: begin
            end
         endcase
      end
   end

   sop_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .status    (status),
      .q_valid   (q_valid),
      .q_item    (q_item)
   );

   sop_back u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_item    (q_item),
      .status    (status),
      .threshold (threshold_ff),
      .degree    (degree_ff),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

@@ design/sop_front.sv @@
// front end: takes request words, drops those without a pc, queues the rest
module sop_front
   import sop_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   input  logic            req_valid,
   output logic            req_ready,
   input  req_type         req_data,
   input  back_status_type status,
   output logic            q_valid,
   output job_type         q_item
);

   job_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QPTR_W:0]     count_ff, count_in;
   logic                push;
   logic                pop;

   assign req_ready = !status.clearing && (count_ff != (QPTR_W+1)'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready && req_data.has_pc;
   assign pop       = status.pop;
   assign q_valid   = (count_ff != '0);
   assign q_item    = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff] <= '{pc: req_data.pc, address: req_data.address,
                                  secure: req_data.secure};
      end
   end

   a_no_pop_when_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> q_valid)
      else $error("queue popped while empty");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QPTR_W+1)'(QUEUE_DEPTH))
      else $error("queue count overflow");

   a_full_blocks_input: assert property (@(posedge clock) disable iff (reset)
      (count_ff == (QPTR_W+1)'(QUEUE_DEPTH)) |-> !req_ready)
      else $error("request taken while queue full");

endmodule

@@ design/sop_back.sv @@
// back end: sampler lookup, predictor training, confidence test and prefetch issue
module sop_back
   import sop_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              q_valid,
   input  job_type           q_item,
   output back_status_type   status,
   input  logic [THR_W-1:0]  threshold,
   input  logic [DEG_W-1:0]  degree,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rsp_type           rsp_data
);

   state_type state_ff, state_in;

   // memories
   row_type  samp_mem [SAMPLER_SETS];
   row_type  samp_rd_ff;
   pred_type pred_mem [PRED_DEPTH];
   pred_type pred_rd_ff;
   logic [SAMPLER_WAYS-1:0] valid_ff [SAMPLER_SETS];

   logic [SET_BITS-1:0] samp_raddr;
   logic                samp_we;
   row_type             samp_wdata;
   logic [SIG_W-1:0]    pred_raddr;
   logic                pred_we;
   logic [SIG_W-1:0]    pred_waddr;
   pred_type            pred_wdata;

   // working registers
   job_type              job_ff;
   logic [SIG_W-1:0]     clr_cnt_ff;
   logic                 hit_ff;
   logic [SIG_W-1:0]     train_idx_ff;
   logic [ADDR_W-1:0]    train_last_ff;
   pred_type             train_new_ff;
   logic [ADDR_W-1:0]    cur_addr_ff;
   logic [DEG_W-1:0]     d_ff;
   logic [DEG_W-1:0]     n_ff;

   logic [SET_BITS-1:0]  set_cur;
   logic [TAG_W-1:0]     tag_cur;
   logic [SIG_W-1:0]     pc_idx;

   // lookup results
   logic [SAMPLER_WAYS-1:0] vld;
   logic                    hit;
   logic [WAY_W-1:0]        hit_way;
   logic                    have_inv;
   logic [WAY_W-1:0]        victim;
   logic [WAY_W-1:0]        chosen;
   logic [WAY_W-1:0]        old_age;
   row_type                 new_row;
   logic [SIG_W-1:0]        train_sig;
   logic [ADDR_W-1:0]       train_last;

   // train and check
   pred_type             train_new;
   pred_type             pc_entry;
   logic [CMP_W-1:0]     conf_scaled;
   logic [CMP_W-1:0]     thr_scaled;
   logic                 confident;
   logic [DEG_W-1:0]     n_sat;
   logic                 last_word;

   assign set_cur = job_ff.address[BLOCK_SHIFT +: SET_BITS];
   assign tag_cur = job_ff.address[ADDR_W-1 -: TAG_W];
   assign pc_idx  = job_ff.pc[SIG_W-1:0];

   // sampler set lookup, victim choice and recency update
   always_comb begin
      hit      = 1'b0;
      hit_way  = '0;
      have_inv = 1'b0;
      victim   = '0;
      for (int w = 0; w < SAMPLER_WAYS; w++) begin
         vld[w] = valid_ff[set_cur][w];
      end
      for (int w = 0; w < SAMPLER_WAYS; w++) begin
         if (!hit && vld[w] && samp_rd_ff[w].tag == tag_cur
             && samp_rd_ff[w].secure == job_ff.secure) begin
            hit     = 1'b1;
            hit_way = WAY_W'(w);
         end
      end
      for (int w = 0; w < SAMPLER_WAYS; w++) begin
         if (!have_inv && !vld[w]) begin
            have_inv = 1'b1;
            victim   = WAY_W'(w);
         end
      end
      if (!have_inv) begin
         for (int w = 1; w < SAMPLER_WAYS; w++) begin
            if (samp_rd_ff[w].age > samp_rd_ff[victim].age) begin
               victim = WAY_W'(w);
            end
         end
      end
      chosen  = hit ? hit_way : victim;
      old_age = vld[chosen] ? samp_rd_ff[chosen].age : WAY_W'(SAMPLER_WAYS - 1);
      // ways that are not valid count as zero
      train_sig  = vld[chosen] ? samp_rd_ff[chosen].sig : '0;
      train_last = vld[chosen] ? samp_rd_ff[chosen].last_address : '0;
      for (int v = 0; v < SAMPLER_WAYS; v++) begin
         new_row[v] = samp_rd_ff[v];
         if (WAY_W'(v) != chosen && vld[v] && samp_rd_ff[v].age < old_age) begin
            new_row[v].age = samp_rd_ff[v].age + 1'b1;
         end
      end
      new_row[chosen] = '{secure: job_ff.secure, tag: tag_cur, sig: pc_idx,
                          last_address: job_ff.address, age: '0};
   end

   // counter training and confidence test
   always_comb begin
      train_new = pred_rd_ff;
      if (hit_ff) begin
         if (pred_rd_ff.conf != '0) begin
            train_new.conf = pred_rd_ff.conf - 1'b1;
         end
      end else begin
         if (pred_rd_ff.conf != CONF_BITS'(CONF_MAX)) begin
            train_new.conf = pred_rd_ff.conf + 1'b1;
         end
         train_new.offset = job_ff.address - train_last_ff;
      end
      // the pc entry may be the one just trained
      pc_entry    = (pc_idx == train_idx_ff) ? train_new_ff : pred_rd_ff;
      conf_scaled = CMP_W'(pc_entry.conf) * CMP_W'(PERCENT_SCALE);
      thr_scaled  = CMP_W'(threshold) * CMP_W'(CONF_MAX);
      confident   = (conf_scaled >= thr_scaled);
      n_sat       = (degree > DEG_W'(MAX_DEGREE)) ? DEG_W'(MAX_DEGREE) : degree;
      last_word   = (d_ff + 1'b1 == n_ff);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (clr_cnt_ff == SIG_W'(PRED_DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_valid) begin
               state_in = S_LOOKUP;
            end
         end
         S_LOOKUP: state_in = S_TRAIN;
         S_TRAIN:  state_in = S_CHECK;
         S_CHECK: begin
            state_in = (confident && n_sat != '0) ? S_EMIT : S_IDLE;
         end
         S_EMIT: begin
            if (rsp_ready && last_word) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // outputs and memory controls
   always_comb begin
      status.pop      = 1'b0;
      status.clearing = 1'b0;
      samp_raddr      = q_item.address[BLOCK_SHIFT +: SET_BITS];
      samp_we         = 1'b0;
      samp_wdata      = new_row;
      pred_raddr      = train_sig;
      pred_we         = 1'b0;
      pred_waddr      = train_idx_ff;
      pred_wdata      = train_new;
      rsp_valid       = 1'b0;
      case (state_ff)
         S_CLEAR: begin
            status.clearing = 1'b1;
            pred_we         = 1'b1;
            pred_waddr      = clr_cnt_ff;
            pred_wdata      = '{conf: CONF_BITS'(INIT_CONF), offset: '0};
         end
         S_IDLE: begin
            status.pop = q_valid;
         end
         S_LOOKUP: begin
            samp_we = 1'b1;
         end
         S_TRAIN: begin
            pred_we    = 1'b1;
            pred_raddr = pc_idx;
         end
         S_CHECK: begin
         end
         S_EMIT: begin
            rsp_valid = 1'b1;
         end
         default: begin
         end
      endcase
   end

   assign rsp_data = '{prefetch_address: cur_addr_ff, last: last_word};

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= S_CLEAR;
         clr_cnt_ff <= '0;
         for (int s = 0; s < SAMPLER_SETS; s++) begin
            valid_ff[s] <= '0;
         end
      end else begin
         state_ff <= state_in;
         if (state_ff == S_CLEAR) begin
            clr_cnt_ff <= clr_cnt_ff + 1'b1;
         end
         if (samp_we) begin
            valid_ff[set_cur][chosen] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      samp_rd_ff <= samp_mem[samp_raddr];
      if (samp_we) begin
         samp_mem[set_cur] <= samp_wdata;
      end
   end

   always_ff @(posedge clock) begin
      pred_rd_ff <= pred_mem[pred_raddr];
      if (pred_we) begin
         pred_mem[pred_waddr] <= pred_wdata;
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               job_ff <= q_item;
            end
         end
         S_LOOKUP: begin
            hit_ff        <= hit;
            train_idx_ff  <= train_sig;
            train_last_ff <= train_last;
         end
         S_TRAIN: begin
            train_new_ff <= train_new;
         end
         S_CHECK: begin
            cur_addr_ff <= job_ff.address + pc_entry.offset;
            d_ff        <= '0;
            n_ff        <= n_sat;
         end
         S_EMIT: begin
            if (rsp_ready) begin
               cur_addr_ff <= cur_addr_ff + ADDR_W'(1 << BLOCK_SHIFT);
               d_ff        <= d_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   a_more_words: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_data.last) |=> rsp_valid)
      else $error("prefetch burst cut short");

   a_burst_ends: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && rsp_data.last) |=> !rsp_valid)
      else $error("word after final prefetch");

   a_no_pop_clearing: assert property (@(posedge clock) disable iff (reset)
      status.clearing |-> !status.pop)
      else $error("job taken during clearing pass");

endmodule

@@ tb/sv/sampled_offset_prefetcher_unit_test.sv @@
// testbench for the sampled offset prefetcher: directed and random accesses checked against a predictor
module sampled_offset_prefetcher_unit_test;
   import sop_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_type               req_data = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   sampled_offset_prefetcher_unit i_dut (.*);

   always #5 clock = ~clock;

   // predictor state
   logic [THR_W-1:0]     threshold_reg;
   logic [DEG_W-1:0]     degree_reg;
   logic [CONF_BITS-1:0] conf_tab [PRED_DEPTH];
   logic [ADDR_W-1:0]    offset_tab [PRED_DEPTH];
   logic                 smp_valid [SAMPLER_DEPTH];
   logic                 smp_secure [SAMPLER_DEPTH];
   logic [TAG_W-1:0]     smp_tag [SAMPLER_DEPTH];
   logic [SIG_W-1:0]     smp_sig [SAMPLER_DEPTH];
   logic [ADDR_W-1:0]    smp_addr [SAMPLER_DEPTH];
   int unsigned          smp_age [SAMPLER_DEPTH];

   rsp_type expected_prefetches [$];
   int      mismatches = 0;
   logic    rsp_stall_on = 1'b1;
   int      rsp_gap = 0;

   task automatic report(input string what);
      $display("mismatch: %s", what);
      mismatches++;
   endtask

   task automatic predictor_reset();
      threshold_reg = THRESHOLD_RESET;
      degree_reg = DEGREE_RESET;
      for (int i = 0; i < PRED_DEPTH; i++) begin
         conf_tab[i] = CONF_BITS'(INIT_CONF);
         offset_tab[i] = '0;
      end
      for (int i = 0; i < SAMPLER_DEPTH; i++) begin
         smp_valid[i] = 1'b0; smp_secure[i] = 1'b0; smp_tag[i] = '0;
         smp_sig[i] = '0; smp_addr[i] = '0; smp_age[i] = 0;
      end
   endtask

   task automatic refresh_recency(input int base, input int w);
      int unsigned old_age;
      old_age = smp_valid[base+w] ? smp_age[base+w] : SAMPLER_WAYS - 1;
      for (int v = 0; v < SAMPLER_WAYS; v++)
         if (v != w && smp_valid[base+v] && smp_age[base+v] < old_age)
            smp_age[base+v]++;
      smp_age[base+w] = 0;
   endtask

   task automatic predict_prefetches(input req_type a);
      logic [ADDR_W-BLOCK_SHIFT-1:0] blk;
      logic [TAG_W-1:0]  tg;
      logic [SIG_W-1:0]  idx;
      logic [ADDR_W-1:0] target;
      int base, way, n;
      bit hit;
      rsp_type r;
      if (!a.has_pc) return;
      blk = a.address[ADDR_W-1:BLOCK_SHIFT];
      base = int'(blk[SET_BITS-1:0]) * SAMPLER_WAYS;
      tg = blk[ADDR_W-BLOCK_SHIFT-1:SET_BITS];
      hit = 1'b0; way = 0;
      for (int w = 0; w < SAMPLER_WAYS; w++)
         if (!hit && smp_valid[base+w] && smp_tag[base+w] == tg
             && smp_secure[base+w] == a.secure) begin
            hit = 1'b1; way = w;
         end
      if (hit) begin
         idx = smp_sig[base+way];
         if (conf_tab[idx] > 0) conf_tab[idx]--;
         refresh_recency(base, way);
      end else begin
         bit got;
         got = 1'b0;
         for (int w = 0; w < SAMPLER_WAYS; w++)
            if (!got && !smp_valid[base+w]) begin got = 1'b1; way = w; end
         if (!got)
            for (int w = 1; w < SAMPLER_WAYS; w++)
               if (smp_age[base+w] > smp_age[base+way]) way = w;
         idx = smp_sig[base+way];
         if (conf_tab[idx] < CONF_MAX) conf_tab[idx]++;
         offset_tab[idx] = a.address - smp_addr[base+way];
         refresh_recency(base, way);
         smp_valid[base+way] = 1'b1;
         smp_secure[base+way] = a.secure;
         smp_tag[base+way] = tg;
      end
      smp_sig[base+way] = a.pc[SIG_W-1:0];
      smp_addr[base+way] = a.address;
      idx = a.pc[SIG_W-1:0];
      if (int'(conf_tab[idx]) * PERCENT_SCALE < int'(threshold_reg) * CONF_MAX) return;
      n = (degree_reg > MAX_DEGREE) ? MAX_DEGREE : degree_reg;
      target = a.address + offset_tab[idx];
      for (int d = 0; d < n; d++) begin
         r.prefetch_address = target + (ADDR_W'(d) << BLOCK_SHIFT);
         r.last = (d + 1 == n);
         expected_prefetches.insert(expected_prefetches.size(), r);
      end
   endtask

   task automatic send_access(input req_type a);
      int gap;
      gap = $urandom_range(0, 8);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= a;
      do @(posedge clock); while (!req_ready);
      predict_prefetches(a);
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (expected_prefetches.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input int value);
      wait_idle();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= CSR_DATA_W'(value);
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == CSR_THRESHOLD) threshold_reg = THR_W'(value);
      else if (idx == CSR_DEGREE) degree_reg = DEG_W'(value);
   endtask

   // result checker with random stalls
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_prefetches.size() == 0) report("unexpected prefetch word");
            else begin
               rsp_type e;
               e = expected_prefetches.pop_front();
               if (rsp_data.prefetch_address !== e.prefetch_address)
                  report($sformatf("address %h, want %h",
                                   rsp_data.prefetch_address, e.prefetch_address));
               if (rsp_data.last !== e.last)
                  report($sformatf("last %b, want %b", rsp_data.last, e.last));
            end
            rsp_gap = rsp_stall_on ? $urandom_range(0, 8) : 0;
         end
         if (rsp_gap > 0) begin
            rsp_ready <= 1'b0;
            rsp_gap--;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   function automatic req_type make_access(input logic [47:0] pc, input logic [47:0] adr,
                                           input logic sec);
      req_type a;
      a.has_pc = 1'b1; a.pc = pc; a.address = adr; a.secure = sec;
      return a;
   endfunction

   task automatic test_directed();
      req_type a;
      a = make_access('0, '0, 1'b0);
      a.has_pc = 1'b0; send_access(a);
      send_access(make_access('1, '1, 1'b1));
      send_access(make_access('0, '0, 1'b0));
      send_access(make_access(48'h40, 48'h1000, 1'b0));
      // same block hit lowers confidence, secure differs counts as a miss
      send_access(make_access(48'h40, 48'h1008, 1'b0));
      send_access(make_access(48'h40, 48'h1008, 1'b1));
      // fill one set past its ways to force lru eviction
      for (int i = 0; i < 6; i++)
         send_access(make_access(48'h80 + i, 48'h2000 + (i << 12), 1'b0));
      // wrap across the top of the address space
      send_access(make_access(48'h81, 48'hFFFF_FFFF_FFC0, 1'b0));
      send_access(make_access(48'h81, 48'h0000_0000_0040, 1'b0));
      send_access(make_access(48'h81, 48'hFFFF_FFFF_F000, 1'b0));
   endtask

   task automatic test_config_extremes();
      write_reg(CSR_DEGREE, 8);
      write_reg(CSR_THRESHOLD, 0);
      for (int i = 0; i < 6; i++)
         send_access(make_access(48'h300, 48'h8000 + (i << 6), 1'b0));
      write_reg(CSR_DEGREE, 15);
      send_access(make_access(48'h300, 48'h9000, 1'b0));
      write_reg(CSR_DEGREE, 0);
      send_access(make_access(48'h300, 48'hA000, 1'b0));
      write_reg(CSR_THRESHOLD, 127);
      write_reg(CSR_DEGREE, 3);
      send_access(make_access(48'h300, 48'hB000, 1'b0));
      write_reg(CSR_THRESHOLD, 100);
      send_access(make_access(48'h300, 48'hC000, 1'b0));
   endtask

   // streams of strided accesses from a few pcs reach confidence; noise mixed in
   task automatic test_random(input int count, input int thr, input int deg);
      logic [47:0] pcs [4];
      logic [47:0] ptr [4];
      logic [47:0] stride [4];
      req_type a;
      int k;
      write_reg(CSR_THRESHOLD, thr);
      write_reg(CSR_DEGREE, deg);
      for (int i = 0; i < 4; i++) begin
         pcs[i] = 48'({$urandom, $urandom});
         ptr[i] = 48'({$urandom, $urandom});
         stride[i] = 48'($urandom_range(1, 64)) << BLOCK_SHIFT;
      end
      for (int n = 0; n < count; n++) begin
         k = $urandom_range(0, 3);
         if ($urandom_range(0, 9) < 7) begin
            a = make_access(pcs[k], ptr[k] + 48'($urandom_range(0, 63)),
                            $urandom_range(0, 9) == 0);
            ptr[k] = ptr[k] + stride[k];
            if ($urandom_range(0, 15) == 0) ptr[k] = ptr[k] - stride[k] * 2;
         end else begin
            a.has_pc = $urandom_range(0, 7) != 0;
            a.pc = 48'({$urandom, $urandom});
            a.address = 48'({$urandom, $urandom});
            a.secure = 1'($urandom);
         end
         if (a.has_pc == 1'b0) n--;
         send_access(a);
         if (n % 100 == 50) rsp_stall_on = ~rsp_stall_on;
      end
   endtask

   initial begin
      predictor_reset();
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_config_extremes();
      test_random(150, 50, 2);
      test_random(150, 30, 8);
      test_random(140, 85, 5);
      wait_idle();
      if (mismatches == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   initial begin
      #5ms;
      $display("end of test: mismatches");
      $finish;
   end

endmodule
